/* rtl/gbu_pkg.sv */
// ----------------------------------------------------------------------------
// gbu_pkg: shared types and constants of the grid bilinear upsampler
// Command and configuration types, sizes and the reciprocal tables used to
// divide by the refine factor and by its square.
// ----------------------------------------------------------------------------
package gbu_pkg;

	// Grid and field sizes
	localparam int MAX_COARSE_X = 256;
	localparam int MAX_COARSE_Y = 256;
	localparam int MAX_REFINE   = 16;
	localparam int COORD_W      = 12;
	localparam int SAMPLE_W     = 32;
	localparam int VALUE_W      = 48;
	localparam int NODE_W       = 8;
	localparam int OFFS_W       = 4;
	localparam int FACTOR_W     = 5;
	localparam int SIZE_W       = 9;
	localparam int GAIN_W       = 32;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;

	// Banked coarse grid: four banks split by column and row parity
	localparam int NUM_BANKS    = 4;
	localparam int HALF_W       = NODE_W - 1;
	localparam int BANK_ADDR_W  = 2 * HALF_W;
	localparam int BANK_DEPTH   = 1 << BANK_ADDR_W;

	// Queues
	localparam int MQ_DEPTH     = 8;
	localparam int MQ_PTR_W     = 3;
	localparam int MQ_CNT_W     = 4;
	localparam int OQ_DEPTH     = 16;
	localparam int OQ_PTR_W     = 4;
	localparam int OQ_CNT_W     = 5;

	localparam logic [GAIN_W-1:0] TOPO_SCALE = 32'd1000;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_REFINE_FACTOR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COARSE_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COARSE_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_MODE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_GAIN = 3'd4;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_TOPO = 2'd1,
		MODE_GAIN = 2'd2
	} scale_mode_t;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_QUERY = 2'd1,
		CMD_MISS  = 2'd2
	} cmd_kind_t;

	// Sanitized configuration
	typedef struct packed {
		logic [FACTOR_W-1:0] factor;
		logic [SIZE_W-1:0]   width;
		logic [SIZE_W-1:0]   height;
		scale_mode_t         mode;
		logic [GAIN_W-1:0]   gain;
	} cfg_t;

	// Classified request passed from front to back
	typedef struct packed {
		cmd_kind_t                  kind;
		logic [NODE_W-1:0]          cx;
		logic [NODE_W-1:0]          cy;
		logic [OFFS_W-1:0]          rx;
		logic [OFFS_W-1:0]          ry;
		logic signed [SAMPLE_W-1:0] sample;
	} cmd_t;

	localparam logic [16:0] LIN_ONE = 17'h1_0000;
	localparam logic [48:0] SQ_ONE  = 49'h1_0000_0000_0000;

	// ceil(2^16 / r): exact quotient of a 12-bit coordinate after >> 16
	function automatic logic [16:0] recip_lin(input logic [FACTOR_W-1:0] factor);
		logic [16:0] m;
		unique case (factor)
			5'd2:    m = (LIN_ONE + 17'd1)  / 17'd2;
			5'd3:    m = (LIN_ONE + 17'd2)  / 17'd3;
			5'd4:    m = (LIN_ONE + 17'd3)  / 17'd4;
			5'd5:    m = (LIN_ONE + 17'd4)  / 17'd5;
			5'd6:    m = (LIN_ONE + 17'd5)  / 17'd6;
			5'd7:    m = (LIN_ONE + 17'd6)  / 17'd7;
			5'd8:    m = (LIN_ONE + 17'd7)  / 17'd8;
			5'd9:    m = (LIN_ONE + 17'd8)  / 17'd9;
			5'd10:   m = (LIN_ONE + 17'd9)  / 17'd10;
			5'd11:   m = (LIN_ONE + 17'd10) / 17'd11;
			5'd12:   m = (LIN_ONE + 17'd11) / 17'd12;
			5'd13:   m = (LIN_ONE + 17'd12) / 17'd13;
			5'd14:   m = (LIN_ONE + 17'd13) / 17'd14;
			5'd15:   m = (LIN_ONE + 17'd14) / 17'd15;
			5'd16:   m = (LIN_ONE + 17'd15) / 17'd16;
			default: m = LIN_ONE;
		endcase
		return m;
	endfunction

	// ceil(2^48 / r^2): exact quotient of a 40-bit magnitude after >> 48
	function automatic logic [48:0] recip_sq(input logic [FACTOR_W-1:0] factor);
		logic [48:0] m;
		unique case (factor)
			5'd2:    m = (SQ_ONE + 49'd3)   / 49'd4;
			5'd3:    m = (SQ_ONE + 49'd8)   / 49'd9;
			5'd4:    m = (SQ_ONE + 49'd15)  / 49'd16;
			5'd5:    m = (SQ_ONE + 49'd24)  / 49'd25;
			5'd6:    m = (SQ_ONE + 49'd35)  / 49'd36;
			5'd7:    m = (SQ_ONE + 49'd48)  / 49'd49;
			5'd8:    m = (SQ_ONE + 49'd63)  / 49'd64;
			5'd9:    m = (SQ_ONE + 49'd80)  / 49'd81;
			5'd10:   m = (SQ_ONE + 49'd99)  / 49'd100;
			5'd11:   m = (SQ_ONE + 49'd120) / 49'd121;
			5'd12:   m = (SQ_ONE + 49'd143) / 49'd144;
			5'd13:   m = (SQ_ONE + 49'd168) / 49'd169;
			5'd14:   m = (SQ_ONE + 49'd195) / 49'd196;
			5'd15:   m = (SQ_ONE + 49'd224) / 49'd225;
			5'd16:   m = (SQ_ONE + 49'd255) / 49'd256;
			default: m = SQ_ONE;
		endcase
		return m;
	endfunction

endpackage

/* rtl/gbu_front.sv */
// ----------------------------------------------------------------------------
// gbu_front: request intake and classification
// Two-stage pipeline: range checks and reciprocal multiply, then remainder.
// Pushes one command per kept request into the command queue.
// ----------------------------------------------------------------------------
module gbu_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  gbu_pkg::cfg_t                         cfg,
	input  logic                                  push,
	output logic                                  full,
	input  logic                                  req_type,
	input  logic [gbu_pkg::COORD_W-1:0]           col,
	input  logic [gbu_pkg::COORD_W-1:0]           row,
	input  logic signed [gbu_pkg::SAMPLE_W-1:0]   sample,
	output logic                                  mq_push,
	output gbu_pkg::cmd_t                         mq_cmd,
	input  logic                                  mq_pop
);

	logic                                 accept;
	logic                                 load_ok;
	logic                                 in_grid;
	logic                                 keep;
	logic [12:0]                          span_x;
	logic [12:0]                          span_y;
	logic [16:0]                          recip;
	logic [28:0]                          prod_x;
	logic [28:0]                          prod_y;
	gbu_pkg::cmd_kind_t                   kind_c;
	logic [gbu_pkg::MQ_CNT_W-1:0]         used_q;
	logic [gbu_pkg::OFFS_W-1:0]           rx_c;
	logic [gbu_pkg::OFFS_W-1:0]           ry_c;

	logic                                 valid_s1;
	gbu_pkg::cmd_kind_t                   kind_s1;
	logic [gbu_pkg::COORD_W-1:0]          col_s1;
	logic [gbu_pkg::COORD_W-1:0]          row_s1;
	logic [gbu_pkg::COORD_W-1:0]          qx_s1;
	logic [gbu_pkg::COORD_W-1:0]          qy_s1;
	logic signed [gbu_pkg::SAMPLE_W-1:0]  sample_s1;
	logic                                 valid_s2;
	gbu_pkg::cmd_t                        cmd_s2;

	// Hold off requests once every queue slot is spoken for
	assign full   = (used_q == gbu_pkg::MQ_CNT_W'(gbu_pkg::MQ_DEPTH));
	assign accept = push && !full;

	// Classify: loads outside the coarse grid are dropped here
	assign span_x  = 13'(cfg.width - 9'd1) * 13'(cfg.factor);
	assign span_y  = 13'(cfg.height - 9'd1) * 13'(cfg.factor);
	assign in_grid = (13'(col) <= span_x) && (13'(row) <= span_y);
	assign load_ok = (13'(col) < 13'(cfg.width)) && (13'(row) < 13'(cfg.height));
	assign keep    = accept && (req_type || load_ok);
	assign kind_c  = !req_type ? gbu_pkg::CMD_LOAD :
	                 (in_grid ? gbu_pkg::CMD_QUERY : gbu_pkg::CMD_MISS);

	// Coarse node index by reciprocal multiply
	assign recip  = gbu_pkg::recip_lin(cfg.factor);
	assign prod_x = 29'(col) * 29'(recip);
	assign prod_y = 29'(row) * 29'(recip);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			used_q   <= used_q + gbu_pkg::MQ_CNT_W'(keep) - gbu_pkg::MQ_CNT_W'(mq_pop);
			valid_s1 <= keep;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1   <= kind_c;
		col_s1    <= col;
		row_s1    <= row;
		qx_s1     <= prod_x[27:16];
		qy_s1     <= prod_y[27:16];
		sample_s1 <= sample;
	end

	// Offset inside the coarse cell
	assign rx_c = gbu_pkg::OFFS_W'(17'(col_s1) - 17'(qx_s1) * 17'(cfg.factor));
	assign ry_c = gbu_pkg::OFFS_W'(17'(row_s1) - 17'(qy_s1) * 17'(cfg.factor));

	always_ff @(posedge clk) begin
		cmd_s2.kind   <= kind_s1;
		cmd_s2.cx     <= (kind_s1 == gbu_pkg::CMD_LOAD) ? col_s1[7:0] : qx_s1[7:0];
		cmd_s2.cy     <= (kind_s1 == gbu_pkg::CMD_LOAD) ? row_s1[7:0] : qy_s1[7:0];
		cmd_s2.rx     <= rx_c;
		cmd_s2.ry     <= ry_c;
		cmd_s2.sample <= sample_s1;
	end

	assign mq_push = valid_s2;
	assign mq_cmd  = cmd_s2;

endmodule

/* rtl/gbu_cmd_queue.sv */
// ----------------------------------------------------------------------------
// gbu_cmd_queue: command queue between front and back
// Small first-in first-out buffer; the front never pushes into a full queue.
// ----------------------------------------------------------------------------
module gbu_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gbu_pkg::cmd_t din,
	input  logic          pop,
	output gbu_pkg::cmd_t dout,
	output logic          empty
);

	gbu_pkg::cmd_t                 entry_q [gbu_pkg::MQ_DEPTH];
	logic [gbu_pkg::MQ_PTR_W-1:0]  wr_ptr_q;
	logic [gbu_pkg::MQ_PTR_W-1:0]  rd_ptr_q;
	logic [gbu_pkg::MQ_CNT_W-1:0]  count_q;

	assign empty = (count_q == '0);
	assign dout  = entry_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + gbu_pkg::MQ_CNT_W'(push) - gbu_pkg::MQ_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

endmodule

/* rtl/gbu_back.sv */
// ----------------------------------------------------------------------------
// gbu_back: grid store, interpolation datapath and result queue
// Loads write one of four parity banks; queries read all four corners in the
// same cycle, weight them, divide by r^2, scale and saturate.
// ----------------------------------------------------------------------------
module gbu_back (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  gbu_pkg::cfg_t                          cfg,
	input  logic                                   mq_empty,
	input  gbu_pkg::cmd_t                          mq_cmd,
	output logic                                   mq_pop,
	output logic                                   empty,
	input  logic                                   pop,
	output logic signed [gbu_pkg::VALUE_W-1:0]     refined_value,
	output logic                                   status
);

	logic                                 issue;
	logic                                 is_query;
	logic                                 deq;
	logic [gbu_pkg::OQ_CNT_W-1:0]         used_q;
	logic [gbu_pkg::NODE_W-1:0]           cx_next;
	logic [gbu_pkg::NODE_W-1:0]           cy_next;
	logic [gbu_pkg::FACTOR_W-1:0]         inv_x;
	logic [gbu_pkg::FACTOR_W-1:0]         inv_y;
	logic [8:0]                           den;
	logic [48:0]                          recip;

	// Stage 1: bank read, weights
	logic signed [gbu_pkg::SAMPLE_W-1:0]  rd_s1 [gbu_pkg::NUM_BANKS];
	logic                                 valid_s1;
	logic                                 miss_s1;
	logic                                 xpar_s1;
	logic                                 ypar_s1;
	logic                                 rxz_s1;
	logic                                 ryz_s1;
	logic [8:0]                           wa_s1;
	logic [8:0]                           wb_s1;
	logic [8:0]                           wc_s1;
	logic [8:0]                           wd_s1;

	// Stage 2: corner products
	logic signed [gbu_pkg::SAMPLE_W-1:0]  top0;
	logic signed [gbu_pkg::SAMPLE_W-1:0]  top1;
	logic signed [gbu_pkg::SAMPLE_W-1:0]  bot0;
	logic signed [gbu_pkg::SAMPLE_W-1:0]  bot1;
	logic signed [gbu_pkg::SAMPLE_W-1:0]  va;
	logic signed [gbu_pkg::SAMPLE_W-1:0]  vb;
	logic signed [gbu_pkg::SAMPLE_W-1:0]  vc;
	logic signed [gbu_pkg::SAMPLE_W-1:0]  vd;
	logic signed [41:0]                   pa_s2;
	logic signed [41:0]                   pb_s2;
	logic signed [41:0]                   pc_s2;
	logic signed [41:0]                   pd_s2;
	logic                                 valid_s2;
	logic                                 miss_s2;

	// Stage 3..7
	logic signed [43:0]                   sum_s3;
	logic                                 valid_s3;
	logic                                 miss_s3;
	logic [43:0]                          mag_c;
	logic [39:0]                          num_s4;
	logic                                 neg_s4;
	logic                                 valid_s4;
	logic                                 miss_s4;
	logic [43:0]                          pll_s5;
	logic [44:0]                          plh_s5;
	logic [43:0]                          phl_s5;
	logic [44:0]                          phh_s5;
	logic                                 neg_s5;
	logic                                 valid_s5;
	logic                                 miss_s5;
	logic [88:0]                          total_c;
	logic [31:0]                          quo_s6;
	logic                                 neg_s6;
	logic                                 valid_s6;
	logic                                 miss_s6;
	logic [gbu_pkg::GAIN_W-1:0]           scale_op;
	logic [63:0]                          prod_s7;
	logic                                 gain_s7;
	logic                                 neg_s7;
	logic                                 valid_s7;
	logic                                 miss_s7;

	// Result formatting and queue
	logic [63:0]                          rnd_c;
	logic [63:0]                          mag64_c;
	logic [gbu_pkg::VALUE_W-1:0]          sat_c;
	logic [gbu_pkg::VALUE_W-1:0]          res_c;
	logic [gbu_pkg::VALUE_W-1:0]          oq_val_q [gbu_pkg::OQ_DEPTH];
	logic                                 oq_sts_q [gbu_pkg::OQ_DEPTH];
	logic [gbu_pkg::OQ_PTR_W-1:0]         oq_wr_q;
	logic [gbu_pkg::OQ_PTR_W-1:0]         oq_rd_q;
	logic [gbu_pkg::OQ_CNT_W-1:0]         oq_count_q;

	// Issue only when a result slot is reserved for every query in flight
	assign issue    = !mq_empty && (used_q < gbu_pkg::OQ_CNT_W'(gbu_pkg::OQ_DEPTH));
	assign mq_pop   = issue;
	assign is_query = issue && (mq_cmd.kind != gbu_pkg::CMD_LOAD);
	assign deq      = pop && !empty;

	assign cx_next = mq_cmd.cx + 1'b1;
	assign cy_next = mq_cmd.cy + 1'b1;

	// Parity banks: each bank holds one of the four (col, row) parity classes
	for (genvar b = 0; b < gbu_pkg::NUM_BANKS; b++) begin : g_bank
		localparam int PX = b % 2;
		localparam int PY = b / 2;
		logic [gbu_pkg::SAMPLE_W-1:0]    mem [gbu_pkg::BANK_DEPTH];
		logic [gbu_pkg::HALF_W-1:0]      xa;
		logic [gbu_pkg::HALF_W-1:0]      ya;
		logic                            we;

		assign xa = (mq_cmd.cx[0] == 1'(PX)) ? mq_cmd.cx[7:1] : cx_next[7:1];
		assign ya = (mq_cmd.cy[0] == 1'(PY)) ? mq_cmd.cy[7:1] : cy_next[7:1];
		assign we = issue && (mq_cmd.kind == gbu_pkg::CMD_LOAD)
		            && (mq_cmd.cx[0] == 1'(PX)) && (mq_cmd.cy[0] == 1'(PY));

		always_ff @(posedge clk) begin
			if (we) begin
				mem[{mq_cmd.cy[7:1], mq_cmd.cx[7:1]}] <= mq_cmd.sample;
			end
			rd_s1[b] <= mem[{ya, xa}];
		end
	end

	// Bilinear weights
	assign inv_x = cfg.factor - gbu_pkg::FACTOR_W'(mq_cmd.rx);
	assign inv_y = cfg.factor - gbu_pkg::FACTOR_W'(mq_cmd.ry);

	always_ff @(posedge clk) begin
		miss_s1 <= (mq_cmd.kind == gbu_pkg::CMD_MISS);
		xpar_s1 <= mq_cmd.cx[0];
		ypar_s1 <= mq_cmd.cy[0];
		rxz_s1  <= (mq_cmd.rx == '0);
		ryz_s1  <= (mq_cmd.ry == '0);
		wa_s1   <= 9'(10'(inv_x) * 10'(inv_y));
		wb_s1   <= 9'(10'(mq_cmd.rx) * 10'(inv_y));
		wc_s1   <= 9'(10'(inv_x) * 10'(mq_cmd.ry));
		wd_s1   <= 9'(10'(mq_cmd.rx) * 10'(mq_cmd.ry));
	end

	// Route banks to corners; drop neighbors that carry zero weight
	assign top0 = ypar_s1 ? rd_s1[2] : rd_s1[0];
	assign top1 = ypar_s1 ? rd_s1[3] : rd_s1[1];
	assign bot0 = ypar_s1 ? rd_s1[0] : rd_s1[2];
	assign bot1 = ypar_s1 ? rd_s1[1] : rd_s1[3];
	assign va   = xpar_s1 ? top1 : top0;
	assign vb   = rxz_s1 ? '0 : (xpar_s1 ? top0 : top1);
	assign vc   = ryz_s1 ? '0 : (xpar_s1 ? bot1 : bot0);
	assign vd   = (rxz_s1 || ryz_s1) ? '0 : (xpar_s1 ? bot0 : bot1);

	always_ff @(posedge clk) begin
		pa_s2   <= va * $signed({1'b0, wa_s1});
		pb_s2   <= vb * $signed({1'b0, wb_s1});
		pc_s2   <= vc * $signed({1'b0, wc_s1});
		pd_s2   <= vd * $signed({1'b0, wd_s1});
		miss_s2 <= miss_s1;
	end

	// Weighted sum
	always_ff @(posedge clk) begin
		sum_s3  <= 44'(pa_s2) + 44'(pb_s2) + 44'(pc_s2) + 44'(pd_s2);
		miss_s3 <= miss_s2;
	end

	// Sign and magnitude, add half the divisor for round to nearest
	assign den   = 9'(10'(cfg.factor) * 10'(cfg.factor));
	assign mag_c = sum_s3[43] ? 44'(-sum_s3) : 44'(sum_s3);

	always_ff @(posedge clk) begin
		num_s4  <= 40'(mag_c) + 40'(den[8:1]);
		neg_s4  <= sum_s3[43];
		miss_s4 <= miss_s3;
	end

	// Divide by r^2: partial products of the reciprocal multiply
	assign recip = gbu_pkg::recip_sq(cfg.factor);

	always_ff @(posedge clk) begin
		pll_s5  <= 44'(num_s4[19:0]) * 44'(recip[23:0]);
		plh_s5  <= 45'(num_s4[19:0]) * 45'(recip[48:24]);
		phl_s5  <= 44'(num_s4[39:20]) * 44'(recip[23:0]);
		phh_s5  <= 45'(num_s4[39:20]) * 45'(recip[48:24]);
		neg_s5  <= neg_s4;
		miss_s5 <= miss_s4;
	end

	assign total_c = 89'(pll_s5) + (89'(plh_s5) << 24) + (89'(phl_s5) << 20)
	                 + (89'(phh_s5) << 44);

	always_ff @(posedge clk) begin
		quo_s6  <= total_c[79:48];
		neg_s6  <= neg_s5;
		miss_s6 <= miss_s5;
	end

	// Scale by mode
	always_comb begin
		unique case (cfg.mode)
			gbu_pkg::MODE_TOPO: scale_op = gbu_pkg::TOPO_SCALE;
			gbu_pkg::MODE_GAIN: scale_op = cfg.gain;
			default:            scale_op = 32'd1;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s7 <= 64'(quo_s6) * 64'(scale_op);
		gain_s7 <= (cfg.mode == gbu_pkg::MODE_GAIN);
		neg_s7  <= neg_s6;
		miss_s7 <= miss_s6;
	end

	// Round the gain product, saturate, restore sign
	assign rnd_c   = prod_s7 + (gain_s7 ? 64'h8000 : 64'h0);
	assign mag64_c = gain_s7 ? {16'h0, rnd_c[63:16]} : rnd_c;

	always_comb begin
		if (neg_s7 && (mag64_c > 64'h8000_0000_0000)) begin
			sat_c = 48'h8000_0000_0000;
		end else if (!neg_s7 && (mag64_c > 64'h7FFF_FFFF_FFFF)) begin
			sat_c = 48'h7FFF_FFFF_FFFF;
		end else begin
			sat_c = mag64_c[47:0];
		end
		if (miss_s7) begin
			res_c = '0;
		end else if (neg_s7) begin
			res_c = 48'(-sat_c);
		end else begin
			res_c = sat_c;
		end
	end

	// Pipeline valids and slot reservation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			used_q   <= used_q + gbu_pkg::OQ_CNT_W'(is_query) - gbu_pkg::OQ_CNT_W'(deq);
			valid_s1 <= is_query;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// Result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q    <= '0;
			oq_rd_q    <= '0;
			oq_count_q <= '0;
		end else begin
			if (valid_s7) begin
				oq_wr_q <= oq_wr_q + 1'b1;
			end
			if (deq) begin
				oq_rd_q <= oq_rd_q + 1'b1;
			end
			oq_count_q <= oq_count_q + gbu_pkg::OQ_CNT_W'(valid_s7)
			              - gbu_pkg::OQ_CNT_W'(deq);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s7) begin
			oq_val_q[oq_wr_q] <= res_c;
			oq_sts_q[oq_wr_q] <= miss_s7;
		end
	end

	assign empty         = (oq_count_q == '0);
	assign refined_value = oq_val_q[oq_rd_q];
	assign status        = oq_sts_q[oq_rd_q];

`ifndef NO_ASSERTIONS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= gbu_pkg::OQ_CNT_W'(gbu_pkg::OQ_DEPTH))
		else $error("result slot reservation exceeds queue depth");

	a_queue_within_reserved: assert property (@(posedge clk) disable iff (!arst_n)
		oq_count_q <= used_q)
		else $error("result queue holds more than reserved");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s7 |-> (oq_count_q < gbu_pkg::OQ_CNT_W'(gbu_pkg::OQ_DEPTH)) || deq)
		else $error("result written into a full queue");
`endif

endmodule

/* rtl/grid_bilinear_upsampler.sv */
// ----------------------------------------------------------------------------
// grid_bilinear_upsampler: bilinear refinement of a stored coarse grid
//
//   channel   direction  handshake          payload
//   request   in         push / full        req_type, col, row, sample
//   result    out        pop / empty        refined_value, status
//   config    in         cfg_wr_en          cfg_index, cfg_data
//
// One request per cycle is accepted sustained while full stays low; the
// pipeline stages themselves never stall. A query result passes through
// two front stages, the command queue and seven back stages.
// The four corners come from four parity banks in the same cycle.
// full rises when eight commands wait in the front and the command queue;
// the back stalls when sixteen results are reserved and not yet popped.
// Reset clears control only; the grid holds unknown values until loaded.
// ----------------------------------------------------------------------------
module grid_bilinear_upsampler (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  logic                                   req_type,
	input  logic [gbu_pkg::COORD_W-1:0]            col,
	input  logic [gbu_pkg::COORD_W-1:0]            row,
	input  logic signed [gbu_pkg::SAMPLE_W-1:0]    sample,
	output logic                                   empty,
	input  logic                                   pop,
	output logic signed [gbu_pkg::VALUE_W-1:0]     refined_value,
	output logic                                   status,
	input  logic                                   cfg_wr_en,
	input  logic [gbu_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [gbu_pkg::CFG_DATA_W-1:0]         cfg_data
);

	logic [gbu_pkg::FACTOR_W-1:0]  refine_factor_q;
	logic [gbu_pkg::SIZE_W-1:0]    coarse_width_q;
	logic [gbu_pkg::SIZE_W-1:0]    coarse_height_q;
	logic [1:0]                    scale_mode_q;
	logic [gbu_pkg::GAIN_W-1:0]    velocity_gain_q;
	gbu_pkg::scale_mode_t          mode_code;
	gbu_pkg::cfg_t                 cfg;
	logic                          mq_push;
	logic                          mq_pop;
	logic                          mq_empty;
	gbu_pkg::cmd_t                 front_cmd;
	gbu_pkg::cmd_t                 head_cmd;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refine_factor_q <= 5'd1;
			coarse_width_q  <= 9'd2;
			coarse_height_q <= 9'd2;
			scale_mode_q    <= gbu_pkg::MODE_NONE;
			velocity_gain_q <= 32'h0001_0000;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				gbu_pkg::REG_REFINE_FACTOR: refine_factor_q <= cfg_data[4:0];
				gbu_pkg::REG_COARSE_WIDTH:  coarse_width_q  <= cfg_data[8:0];
				gbu_pkg::REG_COARSE_HEIGHT: coarse_height_q <= cfg_data[8:0];
				gbu_pkg::REG_SCALE_MODE:    scale_mode_q    <= cfg_data[1:0];
				gbu_pkg::REG_VELOCITY_GAIN: velocity_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp settings into their working ranges
	assign mode_code = gbu_pkg::scale_mode_t'(scale_mode_q);

	always_comb begin
		if (refine_factor_q == '0) begin
			cfg.factor = 5'd1;
		end else if (refine_factor_q > 5'(gbu_pkg::MAX_REFINE)) begin
			cfg.factor = 5'(gbu_pkg::MAX_REFINE);
		end else begin
			cfg.factor = refine_factor_q;
		end
		if (coarse_width_q < 9'd2) begin
			cfg.width = 9'd2;
		end else if (coarse_width_q > 9'(gbu_pkg::MAX_COARSE_X)) begin
			cfg.width = 9'(gbu_pkg::MAX_COARSE_X);
		end else begin
			cfg.width = coarse_width_q;
		end
		if (coarse_height_q < 9'd2) begin
			cfg.height = 9'd2;
		end else if (coarse_height_q > 9'(gbu_pkg::MAX_COARSE_Y)) begin
			cfg.height = 9'(gbu_pkg::MAX_COARSE_Y);
		end else begin
			cfg.height = coarse_height_q;
		end
		cfg.mode = (mode_code == gbu_pkg::MODE_TOPO || mode_code == gbu_pkg::MODE_GAIN)
		           ? mode_code : gbu_pkg::MODE_NONE;
		cfg.gain = velocity_gain_q;
	end

	gbu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.push     (push),
		.full     (full),
		.req_type (req_type),
		.col      (col),
		.row      (row),
		.sample   (sample),
		.mq_push  (mq_push),
		.mq_cmd   (front_cmd),
		.mq_pop   (mq_pop)
	);

	gbu_cmd_queue u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mq_push),
		.din    (front_cmd),
		.pop    (mq_pop),
		.dout   (head_cmd),
		.empty  (mq_empty)
	);

	gbu_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.mq_empty      (mq_empty),
		.mq_cmd        (head_cmd),
		.mq_pop        (mq_pop),
		.empty         (empty),
		.pop           (pop),
		.refined_value (refined_value),
		.status        (status)
	);

endmodule

/* sim/grid_bilinear_upsampler_tb.sv */
// ----------------------------------------------------------------------------
// grid_bilinear_upsampler_tb: self-checking bench of the grid upsampler
// Loads coarse samples and queries refined points under changing refine
// factors, grid sizes and scale modes. A scoreboard predicts every query
// result and checks the popped results in order, with random idling on
// both the request and the result side.
// ----------------------------------------------------------------------------
module grid_bilinear_upsampler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Prediction of refined points and the queue of results still owed
	class upsample_scoreboard;
		typedef struct packed {
			logic [gbu_pkg::VALUE_W-1:0] value;
			logic                        status;
		} result_t;

		logic signed [gbu_pkg::SAMPLE_W-1:0]
			grid [0:gbu_pkg::MAX_COARSE_X*gbu_pkg::MAX_COARSE_Y-1];
		bit                                  written
			[0:gbu_pkg::MAX_COARSE_X*gbu_pkg::MAX_COARSE_Y-1];
		logic [gbu_pkg::FACTOR_W-1:0]        factor;
		logic [gbu_pkg::SIZE_W-1:0]          width;
		logic [gbu_pkg::SIZE_W-1:0]          height;
		logic [1:0]                          mode;
		logic [gbu_pkg::GAIN_W-1:0]          gain;
		result_t                             owed [$];
		int                                  errors;

		function new();
			factor = 1;
			width  = 2;
			height = 2;
			mode   = gbu_pkg::MODE_NONE;
			gain   = 32'h0001_0000;
			errors = 0;
		endfunction

		function int eff_r();
			if (factor == 0) return 1;
			if (factor > gbu_pkg::MAX_REFINE) return gbu_pkg::MAX_REFINE;
			return factor;
		endfunction

		function int eff_w();
			if (width < 2) return 2;
			if (width > gbu_pkg::MAX_COARSE_X) return gbu_pkg::MAX_COARSE_X;
			return width;
		endfunction

		function int eff_h();
			if (height < 2) return 2;
			if (height > gbu_pkg::MAX_COARSE_Y) return gbu_pkg::MAX_COARSE_Y;
			return height;
		endfunction

		function void set_reg(logic [gbu_pkg::CFG_IDX_W-1:0] idx,
		                      logic [gbu_pkg::CFG_DATA_W-1:0] d);
			case (idx)
				gbu_pkg::REG_REFINE_FACTOR: factor = d[gbu_pkg::FACTOR_W-1:0];
				gbu_pkg::REG_COARSE_WIDTH:  width  = d[gbu_pkg::SIZE_W-1:0];
				gbu_pkg::REG_COARSE_HEIGHT: height = d[gbu_pkg::SIZE_W-1:0];
				gbu_pkg::REG_SCALE_MODE:    mode   = d[1:0];
				gbu_pkg::REG_VELOCITY_GAIN: gain   = d;
				default: ;
			endcase
		endfunction

		// Apply a load, or predict the result of a query
		function void note(bit rt, int c, int r, logic [gbu_pkg::SAMPLE_W-1:0] s);
			int rr, ww, hh, cx, cy, cx1, cy1;
			longint fx, fy, sum;
			longint unsigned mag, den, lim;
			bit neg;
			result_t res;
			rr = eff_r();
			ww = eff_w();
			hh = eff_h();
			if (!rt) begin
				if (c < ww && r < hh) begin
					grid[r*gbu_pkg::MAX_COARSE_X + c]    = s;
					written[r*gbu_pkg::MAX_COARSE_X + c] = 1;
				end
				return;
			end
			if (c >= (ww-1)*rr + 1 || r >= (hh-1)*rr + 1) begin
				res.value  = '0;
				res.status = 1'b1;
				owed.push_back(res);
				return;
			end
			cx  = c / rr;
			cy  = r / rr;
			fx  = c % rr;
			fy  = r % rr;
			cx1 = (cx + 1 < ww) ? cx + 1 : ww - 1;
			cy1 = (cy + 1 < hh) ? cy + 1 : hh - 1;
			sum = longint'(grid[cy*gbu_pkg::MAX_COARSE_X + cx])   * ((rr - fx) * (rr - fy))
			    + longint'(grid[cy*gbu_pkg::MAX_COARSE_X + cx1])  * (fx * (rr - fy))
			    + longint'(grid[cy1*gbu_pkg::MAX_COARSE_X + cx])  * ((rr - fx) * fy)
			    + longint'(grid[cy1*gbu_pkg::MAX_COARSE_X + cx1]) * (fx * fy);
			neg = sum < 0;
			mag = neg ? longint'(0) - sum : sum;
			den = rr * rr;
			mag = (mag + den / 2) / den;
			if (mode == gbu_pkg::MODE_TOPO)
				mag = mag * 1000;
			else if (mode == gbu_pkg::MODE_GAIN)
				mag = mag * gain[31:16] + ((mag * gain[15:0] + 64'h8000) >> 16);
			lim = 64'd1 << (gbu_pkg::VALUE_W - 1);
			if (neg) begin
				if (mag > lim) mag = lim;
				mag = 64'd0 - mag;
			end else if (mag > lim - 1) begin
				mag = lim - 1;
			end
			res.value  = mag[gbu_pkg::VALUE_W-1:0];
			res.status = 1'b0;
			owed.push_back(res);
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check(logic [gbu_pkg::VALUE_W-1:0] v, logic st);
			result_t e;
			if (owed.size() == 0) begin
				report($sformatf("unexpected result value=%h status=%b", v, st));
				return;
			end
			e = owed.pop_front();
			if (v !== e.value)
				report($sformatf("refined_value %h, expected %h", v, e.value));
			if (st !== e.status)
				report($sformatf("status %b, expected %b", st, e.status));
		endtask
	endclass

	logic                                clk;
	logic                                arst_n;
	logic                                push;
	logic                                full;
	logic                                req_type;
	logic [gbu_pkg::COORD_W-1:0]         col;
	logic [gbu_pkg::COORD_W-1:0]         row;
	logic signed [gbu_pkg::SAMPLE_W-1:0] sample;
	logic                                empty;
	logic                                pop;
	logic signed [gbu_pkg::VALUE_W-1:0]  refined_value;
	logic                                status;
	logic                                cfg_wr_en;
	logic [gbu_pkg::CFG_IDX_W-1:0]       cfg_index;
	logic [gbu_pkg::CFG_DATA_W-1:0]      cfg_data;

	upsample_scoreboard sb = new();
	bit no_gaps;
	int stall_req;

	grid_bilinear_upsampler dut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Offer one request, hold it until accepted, then idle a while
	task send(bit rt, int c, int r, logic [gbu_pkg::SAMPLE_W-1:0] s);
		int g;
		push     <= 1'b1;
		req_type <= rt;
		col      <= c[gbu_pkg::COORD_W-1:0];
		row      <= r[gbu_pkg::COORD_W-1:0];
		sample   <= s;
		do @(posedge clk); while (full);
		sb.note(rt, c, r, s);
		g = no_gaps ? 0 : $urandom_range(0, 11);
		if (g > 0) begin
			push <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Drain all owed results and let loads settle in the pipeline
	task wait_idle();
		push <= 1'b0;
		@(posedge clk);
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task write_reg(logic [gbu_pkg::CFG_IDX_W-1:0] idx, logic [gbu_pkg::CFG_DATA_W-1:0] d);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		sb.set_reg(idx, d);
	endtask

	task set_config(int r, int w, int h, int m, logic [gbu_pkg::GAIN_W-1:0] g);
		wait_idle();
		write_reg(gbu_pkg::REG_REFINE_FACTOR, r);
		write_reg(gbu_pkg::REG_COARSE_WIDTH, w);
		write_reg(gbu_pkg::REG_COARSE_HEIGHT, h);
		write_reg(gbu_pkg::REG_SCALE_MODE, m);
		write_reg(gbu_pkg::REG_VELOCITY_GAIN, g);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function logic [gbu_pkg::SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 65535) - 32768;
			default: return $urandom;
		endcase
	endfunction

	// One random request, mostly around a window of coarse nodes; a query whose
	// corners are not all loaded turns into a load of the missing corner
	task rand_item(int wx, int wy);
		int rr, ww, hh, c, r, cx, cy, cx1, cy1, k;
		int nx [4];
		int ny [4];
		rr = sb.eff_r();
		ww = sb.eff_w();
		hh = sb.eff_h();
		k = $urandom_range(0, 99);
		if (k < 8) begin
			send(1'b0, $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom);
		end else if (k < 18) begin
			if ($urandom_range(0, 1)) begin
				c = $urandom_range((ww-1)*rr + 1, 4095);
				r = $urandom_range(0, 4095);
			end else begin
				c = $urandom_range(0, 4095);
				r = $urandom_range((hh-1)*rr + 1, 4095);
			end
			send(1'b1, c, r, $urandom);
		end else if (k < 26) begin
			c = wx + $urandom_range(0, 3);
			r = wy + $urandom_range(0, 3);
			if (c > ww - 1) c = ww - 1;
			if (r > hh - 1) r = hh - 1;
			send(1'b0, c, r, rand_sample());
		end else begin
			c = wx*rr + $urandom_range(0, 3*rr);
			r = wy*rr + $urandom_range(0, 3*rr);
			if (c > (ww-1)*rr) c = (ww-1)*rr;
			if (r > (hh-1)*rr) r = (hh-1)*rr;
			cx  = c / rr;
			cy  = r / rr;
			cx1 = (cx + 1 < ww) ? cx + 1 : ww - 1;
			cy1 = (cy + 1 < hh) ? cy + 1 : hh - 1;
			nx = '{cx, cx1, cx, cx1};
			ny = '{cy, cy, cy1, cy1};
			for (int i = 0; i < 4; i++) begin
				if (!sb.written[ny[i]*gbu_pkg::MAX_COARSE_X + nx[i]]) begin
					send(1'b0, nx[i], ny[i], rand_sample());
					return;
				end
			end
			send(1'b1, c, r, $urandom);
		end
	endtask

	// Result side: pop with random gaps, honor long hold-off requests
	initial begin
		int g;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			sb.check(refined_value, status);
			if (stall_req > 0) begin
				pop <= 1'b0;
				repeat (stall_req) @(posedge clk);
				stall_req = 0;
			end else begin
				g = no_gaps ? 0 : $urandom_range(0, 11);
				if (g > 0) begin
					pop <= 1'b0;
					repeat (g) @(posedge clk);
				end
			end
		end
	end

	// Request side: directed part, then random phases
	initial begin
		int wx, wy, n;
		arst_n    = 1'b0;
		push      = 1'b0;
		req_type  = 1'b0;
		col       = '0;
		row       = '0;
		sample    = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		no_gaps   = 0;
		stall_req = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: 2x2 grid, factor one, extreme samples
		send(1'b0, 0, 0, 32'h7FFF_FFFF);
		send(1'b0, 1, 0, 32'h8000_0000);
		send(1'b0, 0, 1, 32'hFFFF_FFFF);
		send(1'b0, 1, 1, 32'h0000_0000);
		send(1'b0, 2, 0, 32'h1234_5678);
		send(1'b0, 4095, 4095, 32'h5555_5555);
		send(1'b1, 0, 0, 0);
		send(1'b1, 1, 1, 0);
		send(1'b1, 2, 0, 0);
		send(1'b1, 4095, 4095, 32'hFFFF_FFFF);

		// Largest factor: midpoints, last node, ties in rounding
		set_config(16, 2, 2, gbu_pkg::MODE_TOPO, 32'h0001_0000);
		send(1'b1, 8, 8, 0);
		send(1'b1, 16, 16, 0);
		send(1'b1, 15, 1, 0);
		send(1'b1, 17, 0, 0);
		send(1'b0, 1, 1, 32'h0000_0001);
		send(1'b1, 8, 8, 0);

		// Saturating gain, then the unknown mode and out-of-range registers
		set_config(0, 0, 1, gbu_pkg::MODE_GAIN, 32'hFFFF_FFFF);
		send(1'b1, 0, 0, 0);
		send(1'b1, 0, 1, 0);
		send(1'b1, 1, 0, 0);
		set_config(31, 511, 300, 3, 32'h0000_0000);
		send(1'b0, 255, 255, 32'h8000_0000);
		send(1'b0, 254, 255, 32'h7FFF_FFFF);
		send(1'b0, 255, 254, 32'h0000_FFFF);
		send(1'b0, 254, 254, 32'hFFFF_0000);
		send(1'b1, 4080, 4080, 0);
		send(1'b1, 4070, 4075, 0);
		send(1'b1, 4081, 0, 0);

		// Random phases over many settings
		for (int p = 0; p < 14; p++) begin
			case (p)
				0: set_config(1, 256, 256, gbu_pkg::MODE_NONE, 32'h0001_0000);
				1: set_config(16, 2, 2, gbu_pkg::MODE_GAIN, 32'hFFFF_FFFF);
				2: set_config(17, 257, 3, gbu_pkg::MODE_TOPO, 32'h0000_0000);
				3: set_config(0, 3, 511, 3, 32'h8000_8000);
				default: set_config($urandom_range(0, 31), $urandom_range(0, 511),
				                     $urandom_range(0, 511), $urandom_range(0, 3), $urandom);
			endcase
			no_gaps = (p % 4 == 2);
			n = 0;
			while (n < 135) begin
				if (n % 40 == 0) begin
					wx = $urandom_range(0, 3) == 0 ? sb.eff_w() - 1 : $urandom_range(0, sb.eff_w() - 1);
					wy = $urandom_range(0, 3) == 0 ? sb.eff_h() - 1 : $urandom_range(0, sb.eff_h() - 1);
				end
				// Long hold-off on the result side while requests keep coming
				if (n == 60 && p % 3 == 1)
					stall_req = 300;
				// Pause until every owed result has come back
				if (n == 100 && p % 3 == 0) begin
					push <= 1'b0;
					@(posedge clk);
					while (sb.owed.size() != 0) @(posedge clk);
				end
				rand_item(wx, wy);
				n++;
			end
		end

		wait_idle();
		repeat (30) @(posedge clk);
		if (sb.owed.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.owed.size()));
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Hang guard
	initial begin
		#5ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule
